>>> rtl/assert_macros.svh
// Assertion helpers shared by the parser RTL.
// Each macro checks a property on the rising clock edge and stays quiet
// while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`endif

>>> rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Types, codes and constants shared by the RIFF/WAVE stream parser modules.
// ----------------------------------------------------------------------------
package rws_pkg;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_RIFF      = 3'd0,
    PH_CHUNK_HDR = 3'd1,
    PH_FMT       = 3'd2,
    PH_SKIP      = 3'd3,
    PH_DATA      = 3'd4,
    PH_DONE      = 3'd5,
    PH_HALT      = 3'd6
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // Status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_NOT16      = 3'd2,
    ST_NO_DATA    = 3'd3,
    ST_TRUNC      = 3'd4
  } status_e;

  // Four-character tags as they read little-endian from the stream.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Format defaults used until a fmt chunk supplies a field.
  localparam logic [15:0] DEFAULT_CHANNELS = 16'd2;
  localparam logic [31:0] DEFAULT_RATE     = 32'd44100;
  localparam logic [15:0] DEFAULT_BITS     = 16'd16;

  // Byte positions inside the headers.
  localparam logic [3:0] RIFF_LAST_IDX   = 4'd11;
  localparam logic [3:0] WAVE_FIRST_IDX  = 4'd8;
  localparam logic [3:0] TAG_BYTES       = 4'd4;
  localparam logic [3:0] HDR_LAST_IDX    = 4'd7;
  localparam logic [3:0] FMT_CH_IDX      = 4'd3;
  localparam logic [3:0] FMT_RATE_IDX    = 4'd7;
  localparam logic [3:0] FMT_BITS_IDX    = 4'd15;
  localparam logic [4:0] FMT_FIELD_BYTES = 5'd16;

  // One input item.
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] bits_per_sample;
    logic [2:0]  status;
    logic        last_of_data;
  } out_item_t;

  // Step status from the parser core to the register stages.
  typedef struct packed {
    logic consume;
    logic res_valid;
  } core_sts_t;

  // Selects one byte of a tag word, least significant first.
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = tag[7:0];
      2'd1:    b = tag[15:8];
      2'd2:    b = tag[23:16];
      default: b = tag[31:24];
    endcase
    return b;
  endfunction

endpackage

>>> rtl/rws_in_reg.sv
// ----------------------------------------------------------------------------
// rws_in_reg
// Input register: holds one accepted request until the parser core takes it.
// ----------------------------------------------------------------------------
module rws_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  rws_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  input  logic              consume_i,
  output logic              item_valid_o,
  output rws_pkg::in_item_t item_o
);
  import rws_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // The slot is free when empty or when its item leaves in this cycle.
  assign in_stall_o = valid_q && !consume_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/rws_parse_core.sv
// ----------------------------------------------------------------------------
// rws_parse_core
// Parser state and the per-byte step logic: header checks, chunk walking,
// fmt field capture, skipping and data pass-through.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rws_parse_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  rws_pkg::in_item_t  item_i,
  input  logic               slot_free_i,
  output rws_pkg::core_sts_t sts_o,
  output rws_pkg::out_item_t res_o
);
  import rws_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [32:0] rem_q, rem_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  status_e     status_q, status_d;

  logic        has_res;
  out_item_t   res;
  logic [7:0]  b;
  logic        bad;
  logic [31:0] tag_n;
  logic [31:0] len_n;
  logic [4:0]  fmt_n;
  logic [32:0] skip_cnt;
  logic [32:0] rem_dec;
  status_e     st;
  logic        consume;

  assign b       = item_i.stream_byte;
  assign rem_dec = (rem_q != 33'd0) ? (rem_q - 33'd1) : rem_q;

  // Next state and the result of the current byte.
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    tag_d    = tag_q;
    len_d    = len_q;
    rem_d    = rem_q;
    ch_d     = ch_q;
    rate_d   = rate_q;
    bits_d   = bits_q;
    status_d = status_q;
    has_res  = 1'b0;
    res      = '0;
    bad      = 1'b0;
    tag_n    = tag_q;
    len_n    = len_q;
    fmt_n    = FMT_FIELD_BYTES;
    skip_cnt = '0;
    st       = status_q;

    if (item_i.end_of_stream) begin
      // End marker: report final status and return to reset state.
      if (phase_q == PH_RIFF) begin
        st = ST_BAD_HEADER;
      end else if (phase_q == PH_DATA) begin
        st = ST_TRUNC;
      end
      has_res    = 1'b1;
      res.kind   = KIND_STATUS;
      res.status = st;
      phase_d    = PH_RIFF;
      idx_d      = '0;
      tag_d      = '0;
      len_d      = '0;
      rem_d      = '0;
      ch_d       = DEFAULT_CHANNELS;
      rate_d     = DEFAULT_RATE;
      bits_d     = DEFAULT_BITS;
      status_d   = ST_NO_DATA;
    end else begin
      case (phase_q)
        PH_RIFF: begin
          // Check the RIFF and WAVE tags; the size field is not checked.
          if (idx_q < TAG_BYTES) begin
            bad = b != tag_byte(TAG_RIFF, idx_q[1:0]);
          end else if (idx_q >= WAVE_FIRST_IDX && idx_q <= RIFF_LAST_IDX) begin
            bad = b != tag_byte(TAG_WAVE, idx_q[1:0]);
          end
          if (bad) begin
            status_d = ST_BAD_HEADER;
            phase_d  = PH_HALT;
          end else if (idx_q >= RIFF_LAST_IDX) begin
            phase_d = PH_CHUNK_HDR;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end

        PH_CHUNK_HDR: begin
          // Shift in the tag, then the little-endian length.
          if (idx_q < TAG_BYTES) begin
            tag_n = {b, tag_q[31:8]};
          end else begin
            len_n = {b, len_q[31:8]};
          end
          tag_d = tag_n;
          len_d = len_n;
          if (idx_q < HDR_LAST_IDX) begin
            idx_d = idx_q + 4'd1;
          end else begin
            idx_d = '0;
            if (tag_n == TAG_FMT) begin
              if (len_n == 32'd0) begin
                rem_d   = '0;
                phase_d = PH_CHUNK_HDR;
              end else begin
                tag_d   = '0;
                phase_d = PH_FMT;
              end
            end else if (tag_n == TAG_DATA) begin
              // Format report; only 16-bit samples go on to the data.
              st                  = (bits_q == DEFAULT_BITS) ? ST_OK : ST_NOT16;
              has_res             = 1'b1;
              res.kind            = KIND_FORMAT;
              res.channel_count   = ch_q;
              res.rate_hz         = rate_q;
              res.bits_per_sample = bits_q;
              res.status          = st;
              if (st != ST_OK) begin
                status_d = ST_NOT16;
                phase_d  = PH_HALT;
              end else if (len_n == 32'd0) begin
                status_d = ST_OK;
                phase_d  = PH_DONE;
              end else begin
                rem_d   = {1'b0, len_n};
                phase_d = PH_DATA;
              end
            end else begin
              // Other chunk: skip its body and the pad byte of odd lengths.
              skip_cnt = {1'b0, len_n} + {32'd0, len_n[0]};
              rem_d    = skip_cnt;
              phase_d  = (skip_cnt == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
            end
          end
        end

        PH_FMT: begin
          // Capture fields once all of their bytes have arrived.
          tag_n = {b, tag_q[31:8]};
          tag_d = tag_n;
          fmt_n = (len_q < 32'd16) ? len_q[4:0] : FMT_FIELD_BYTES;
          if (idx_q == FMT_CH_IDX) begin
            ch_d = tag_n[31:16];
          end else if (idx_q == FMT_RATE_IDX) begin
            rate_d = tag_n;
          end else if (idx_q == FMT_BITS_IDX) begin
            bits_d = tag_n[31:16];
          end
          if (({1'b0, idx_q} + 5'd1) >= fmt_n) begin
            skip_cnt = {1'b0, len_q - {27'd0, fmt_n}} + {32'd0, len_q[0]};
            rem_d    = skip_cnt;
            phase_d  = (skip_cnt == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
            idx_d    = '0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end

        PH_SKIP: begin
          rem_d = rem_dec;
          if (rem_dec == 33'd0) begin
            phase_d = PH_CHUNK_HDR;
            idx_d   = '0;
          end
        end

        PH_DATA: begin
          // Pass payload bytes and flag the last declared one.
          rem_d            = rem_dec;
          has_res          = 1'b1;
          res.kind         = KIND_DATA;
          res.data_byte    = b;
          res.last_of_data = (rem_dec == 33'd0);
          if (rem_dec == 33'd0) begin
            status_d = ST_OK;
            phase_d  = PH_DONE;
          end
        end

        default: begin
          // Done or halted: bytes are ignored.
        end
      endcase
    end
  end

  // An item leaves when its result has a free slot, or when it has none.
  assign consume         = item_valid_i && (slot_free_i || !has_res);
  assign sts_o.consume   = consume;
  assign sts_o.res_valid = consume && has_res;
  assign res_o           = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_RIFF;
      idx_q    <= '0;
      tag_q    <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      ch_q     <= DEFAULT_CHANNELS;
      rate_q   <= DEFAULT_RATE;
      bits_q   <= DEFAULT_BITS;
      status_q <= ST_NO_DATA;
    end else if (consume) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      ch_q     <= ch_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      status_q <= status_d;
    end
  end

  // A byte result only comes from the data phase or a chunk header's end.
  `ASSERT_ALWAYS(a_res_source, clk_i, rst_ni, (sts_o.res_valid && !item_i.end_of_stream) |-> (phase_q == PH_DATA || (phase_q == PH_CHUNK_HDR && idx_q == HDR_LAST_IDX)), "result from a phase that gives none")
  // The end marker always returns the parser to its reset phase.
  `ASSERT_ALWAYS(a_eos_reset, clk_i, rst_ni, (consume && item_i.end_of_stream) |=> (phase_q == PH_RIFF && idx_q == 4'd0 && status_q == ST_NO_DATA), "end marker did not reset the parser")
  // In the data phase at least one declared byte is still due.
  `ASSERT_NEVER(a_data_rem, clk_i, rst_ni, phase_q == PH_DATA && rem_q == 33'd0, "data phase with no bytes left")
  // Data only flows for 16-bit samples.
  `ASSERT_NEVER(a_data_bits, clk_i, rst_ni, phase_q == PH_DATA && bits_q != DEFAULT_BITS, "data phase with a sample width other than 16")

endmodule

>>> rtl/rws_out_reg.sv
// ----------------------------------------------------------------------------
// rws_out_reg
// Result register: holds one result request until the consumer takes it.
// ----------------------------------------------------------------------------
module rws_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  rws_pkg::out_item_t res_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  output rws_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);
  import rws_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  // The register can load when empty or when its request is taken now.
  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> rtl/riff_wave_stream_parser.sv
// ----------------------------------------------------------------------------
// riff_wave_stream_parser
// Parses a RIFF/WAVE byte stream: checks the file header, walks chunks,
// reports the fmt fields at the data chunk and passes the data bytes on.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake              | Payload
//  --------+-----+------------------------+------------------------------------
//  in      | in  | in_valid_i / in_stall_o   | stream_byte, end_of_stream
//  out     | out | out_valid_o / out_stall_i | kind, data_byte, format, status
//
// One byte is taken per cycle unless a stalled output holds it up; a request
// is held in the input register, and its result is offered from the result
// register until the consumer takes it.
// The parser state updates in a single step per byte between those registers.
// Reset puts the parser in its file-header phase with the format defaults.
// A stalled output holds its result; one more request is still taken into the
// input register before in_stall_o rises.
// ----------------------------------------------------------------------------
module riff_wave_stream_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  rws_pkg::in_item_t  in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output rws_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);
  import rws_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      slot_free;
  core_sts_t sts;
  out_item_t res;

  // Input register.
  rws_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .consume_i    (sts.consume),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Parser state and step logic.
  rws_parse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .slot_free_i  (slot_free),
    .sts_o        (sts),
    .res_o        (res)
  );

  // Result register.
  rws_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (sts.res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> sim/wave_parse_sb_pkg.sv
// ----------------------------------------------------------------------------
// wave_parse_sb_pkg
// Scoreboard for the RIFF/WAVE stream parser. It tracks the parser state for
// every accepted request and keeps the results those requests must produce.
// ----------------------------------------------------------------------------
package wave_parse_sb_pkg;
  import rws_pkg::*;

  // The only sample width the parser lets through.
  localparam logic [15:0] PCM16_BITS = 16'd16;

  class wave_parse_scoreboard;
    phase_e      phase;
    logic [3:0]  byte_idx;
    logic [31:0] tag_shift;
    logic [31:0] chunk_len;
    logic [32:0] bytes_left;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    status_e     outcome;
    out_item_t   expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    // Parser state after reset and after every end marker.
    function void restart();
      phase      = PH_RIFF;
      byte_idx   = '0;
      tag_shift  = '0;
      chunk_len  = '0;
      bytes_left = '0;
      channels   = DEFAULT_CHANNELS;
      rate       = DEFAULT_RATE;
      bits       = DEFAULT_BITS;
      outcome    = ST_NO_DATA;
    endfunction

    // An empty skip goes straight on to the next chunk header.
    function void skip_bytes(logic [32:0] count);
      bytes_left = count;
      phase      = (count == '0) ? PH_CHUNK_HDR : PH_SKIP;
      byte_idx   = '0;
    endfunction

    // Advances the parser by one accepted request and queues its result.
    function void note_request(in_item_t req);
      out_item_t   res;
      logic [7:0]  b;
      logic [4:0]  fmt_len;
      int unsigned idx;
      bit          bad;
      status_e     st;
      res = '0;
      b   = req.stream_byte;
      idx = byte_idx;
      bad = 1'b0;

      // The end marker reports where the file stopped and resets the parser.
      if (req.end_of_stream) begin
        st = outcome;
        if (phase == PH_RIFF) begin
          st = ST_BAD_HEADER;
        end else if (phase == PH_DATA) begin
          st = ST_TRUNC;
        end
        res.kind   = KIND_STATUS;
        res.status = st;
        expected_q.push_back(res);
        restart();
        return;
      end

      case (phase)
        // File header: RIFF tag, size word, WAVE tag.
        PH_RIFF: begin
          if (idx < 4) begin
            bad = (b != TAG_RIFF[8*idx +: 8]);
          end else if (idx >= 8 && idx < 12) begin
            bad = (b != TAG_WAVE[8*(idx-8) +: 8]);
          end
          if (bad) begin
            outcome = ST_BAD_HEADER;
            phase   = PH_HALT;
          end else if (byte_idx >= RIFF_LAST_IDX) begin
            phase    = PH_CHUNK_HDR;
            byte_idx = '0;
          end else begin
            byte_idx = byte_idx + 4'd1;
          end
        end

        // Chunk header: tag, then little-endian length.
        PH_CHUNK_HDR: begin
          if (byte_idx < TAG_BYTES) begin
            tag_shift = {b, tag_shift[31:8]};
          end else begin
            chunk_len = {b, chunk_len[31:8]};
          end
          if (byte_idx < HDR_LAST_IDX) begin
            byte_idx = byte_idx + 4'd1;
          end else begin
            byte_idx = '0;
            if (tag_shift == TAG_FMT) begin
              if (chunk_len == '0) begin
                skip_bytes('0);
              end else begin
                tag_shift = '0;
                phase     = PH_FMT;
              end
            end else if (tag_shift == TAG_DATA) begin
              st                  = (bits == PCM16_BITS) ? ST_OK : ST_NOT16;
              res.kind            = KIND_FORMAT;
              res.channel_count   = channels;
              res.rate_hz         = rate;
              res.bits_per_sample = bits;
              res.status          = st;
              expected_q.push_back(res);
              if (st != ST_OK) begin
                outcome = ST_NOT16;
                phase   = PH_HALT;
              end else if (chunk_len == '0) begin
                outcome = ST_OK;
                phase   = PH_DONE;
              end else begin
                bytes_left = {1'b0, chunk_len};
                phase      = PH_DATA;
              end
            end else begin
              skip_bytes({1'b0, chunk_len} + chunk_len[0]);
            end
          end
        end

        // Format fields; a field is taken only once all its bytes are in.
        PH_FMT: begin
          fmt_len   = (chunk_len < FMT_FIELD_BYTES) ? chunk_len[4:0] : FMT_FIELD_BYTES;
          tag_shift = {b, tag_shift[31:8]};
          if (byte_idx == FMT_CH_IDX) begin
            channels = tag_shift[31:16];
          end else if (byte_idx == FMT_RATE_IDX) begin
            rate = tag_shift;
          end else if (byte_idx == FMT_BITS_IDX) begin
            bits = tag_shift[31:16];
          end
          if ({1'b0, byte_idx} + 5'd1 >= fmt_len) begin
            skip_bytes({1'b0, chunk_len - 32'(fmt_len)} + chunk_len[0]);
          end else begin
            byte_idx = byte_idx + 4'd1;
          end
        end

        PH_SKIP: begin
          if (bytes_left != '0) bytes_left = bytes_left - 33'd1;
          if (bytes_left == '0) begin
            phase    = PH_CHUNK_HDR;
            byte_idx = '0;
          end
        end

        // Payload bytes pass through until the declared size is used up.
        PH_DATA: begin
          if (bytes_left != '0) bytes_left = bytes_left - 33'd1;
          res.kind         = KIND_DATA;
          res.data_byte    = b;
          res.last_of_data = (bytes_left == '0);
          if (res.last_of_data) begin
            outcome = ST_OK;
            phase   = PH_DONE;
          end
          expected_q.push_back(res);
        end

        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Checks one delivered result against the oldest one still owed.
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result of kind %0d with no request owing one", got.kind);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("channel_count", want.channel_count, got.channel_count);
      compare_field("rate_hz", want.rate_hz, got.rate_hz);
      compare_field("bits_per_sample", want.bits_per_sample, got.bits_per_sample);
      compare_field("status", want.status, got.status);
      compare_field("last_of_data", want.last_of_data, got.last_of_data);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds the RIFF/WAVE stream parser with short directed files and then with
// random files built around each parsing case, with random idle and stall
// cycles on both channels. Every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rws_pkg::*;
  import wave_parse_sb_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  in_item_t  in_data_i;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;
  logic      out_stall_i;

  wave_parse_scoreboard sb = new();

  logic [7:0]  file_bytes[$];
  int unsigned sent_items = 0;
  bit          send_steady = 1'b0;

  riff_wave_stream_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // 10 ns clock.
  always #5ns clk_i = ~clk_i;

  // Hard limit on the run time.
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // Helpers that assemble one file in file_bytes.
  function automatic void put_byte(input logic [7:0] b);
    file_bytes.push_back(b);
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
  endfunction

  function automatic void put_header();
    put_word(TAG_RIFF);
    put_word($urandom);
    put_word(TAG_WAVE);
  endfunction

  // A fmt chunk whose first 16 bytes carry random fields and the given width.
  function automatic void put_fmt(input logic [31:0] len, input logic [15:0] sample_bits);
    logic [127:0] fields;
    fields = {sample_bits, 16'($urandom), $urandom, $urandom, $urandom};
    put_word(TAG_FMT);
    put_word(len);
    for (int unsigned i = 0; i < len; i++) begin
      if (i < 16) put_byte(fields[8*i +: 8]);
      else put_byte(8'($urandom));
    end
    if (len[0]) put_byte(8'($urandom));
  endfunction

  // Some unrelated chunk, with its pad byte when the length is odd.
  function automatic void put_other(input logic [31:0] len);
    put_word($urandom);
    put_word(len);
    repeat (len) put_byte(8'($urandom));
    if (len[0]) put_byte(8'($urandom));
  endfunction

  // Builds one file; the scenario picks which parsing case it aims at.
  function automatic void build_file(input int unsigned scenario);
    logic [31:0] data_len;
    int unsigned n_sent;
    int unsigned cut;
    logic [15:0] odd_bits;
    file_bytes.delete();

    // Broken files: noise, a damaged header or a header cut short.
    if (scenario == 0) begin
      case ($urandom_range(0, 2))
        0: repeat ($urandom_range(1, 16)) put_byte(8'($urandom));
        1: begin
          put_header();
          cut = $urandom_range(0, 11);
          file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
          repeat ($urandom_range(0, 8)) put_byte(8'($urandom));
        end
        default: begin
          put_header();
          cut = $urandom_range(1, 11);
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
      endcase
      return;
    end

    put_header();
    case (scenario)
      // Short fmt chunk: only the fields it fully covers are taken.
      1: put_fmt($urandom_range(1, 15), PCM16_BITS);
      // Repeated fmt chunks around an odd-length chunk.
      2: begin
        put_fmt(16, 16'($urandom));
        put_other(2 * $urandom_range(0, 4) + 1);
        put_fmt($urandom_range(0, 20), PCM16_BITS);
      end
      // A sample width other than sixteen bits.
      3: begin
        odd_bits = 16'($urandom);
        if (odd_bits == PCM16_BITS) odd_bits = 16'd8;
        put_fmt(16 + 2 * $urandom_range(0, 2), odd_bits);
      end
      default: begin
        if ($urandom_range(0, 3) != 0) put_fmt(16, PCM16_BITS);
        if ($urandom_range(0, 1) != 0) put_other($urandom_range(0, 9));
      end
    endcase

    // No data chunk; the file may stop in the middle of a long chunk.
    if (scenario == 6) begin
      if ($urandom_range(0, 1) != 0) begin
        put_word($urandom);
        put_word($urandom | 32'h100);
        repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
      end
      return;
    end

    case (scenario)
      4:       data_len = '0;
      5:       data_len = ($urandom_range(0, 1) != 0) ? ($urandom | 32'h10)
                                                      : $urandom_range(2, 16);
      7:       data_len = $urandom_range(40, 80);
      default: data_len = $urandom_range(1, 16);
    endcase
    put_word(TAG_DATA);
    put_word(data_len);

    // Truncated data, exact data, or data followed by stray bytes.
    n_sent = data_len;
    if (scenario == 5) begin
      n_sent = $urandom_range(0, (data_len > 9) ? 8 : data_len - 1);
    end else if (scenario == 4 || $urandom_range(0, 4) == 0) begin
      n_sent = data_len + $urandom_range(1, 5);
    end
    repeat (n_sent) put_byte(8'($urandom));
  endfunction

  // Offers one request after a random idle gap and waits until it is taken.
  task automatic send_request(input logic [7:0] b, input logic eos);
    in_item_t    req;
    int unsigned gap;
    req.stream_byte   = b;
    req.end_of_stream = eos;
    gap = send_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(req);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Sends the assembled file followed by its end marker.
  task automatic send_file();
    send_steady = ($urandom_range(0, 3) == 0);
    foreach (file_bytes[i]) send_request(file_bytes[i], 1'b0);
    send_request(8'($urandom), 1'b1);
  endtask

  // Result side: random stalls, two long hold-offs, and a check per result.
  initial begin : result_sink
    int unsigned stall_cycles;
    int unsigned taken;
    bit          steady;
    taken       = 0;
    steady      = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (taken % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      if (taken == 30 || taken == 200) begin
        stall_cycles = 120;
      end else begin
        stall_cycles = steady ? 0 : $urandom_range(0, 3);
      end
      if (stall_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(out_data_o);
      taken++;
      @(negedge clk_i);
    end
  end

  // Reset, directed files, random files, then drain and report.
  initial begin : stimulus
    int unsigned file_idx;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // End marker alone, and a wrong first byte followed by more bytes.
    send_request(8'($urandom), 1'b1);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'($urandom), 1'b1);

    // A complete header with no chunks, then a header cut after two bytes.
    file_bytes.delete();
    put_header();
    send_file();
    file_bytes.delete();
    put_byte(TAG_RIFF[7:0]);
    put_byte(TAG_RIFF[15:8]);
    send_file();

    file_idx = 0;
    while (sent_items < 950) begin
      build_file(file_idx % 10);
      send_file();
      file_idx++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
